// ----- sv/wmc_pkg.sv -----
// Shared types, constants and helpers for the wiper motor controller.
`timescale 1ns / 1ps

package wmc_pkg;

    // Width of the free-running millisecond time base
    localparam int TIME_BITS   = 32;
    localparam int INTER_COUNT = 6;
    localparam int DELAY_BITS  = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIME_BITS-1:0]  wmc_time_t;
    typedef logic [DELAY_BITS-1:0] delay_t;

    // Settle delays after motor start
    localparam wmc_time_t INTER_SETTLE = TIME_BITS'(1000);
    localparam wmc_time_t WASH_SETTLE  = TIME_BITS'(100);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CONTROL    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WASH_WIPES = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTER_1    = 3'd2;

    // Speed request codes
    localparam logic [3:0] REQ_PARK        = 4'd0;
    localparam logic [3:0] REQ_SLOW        = 4'd1;
    localparam logic [3:0] REQ_FAST        = 4'd2;
    localparam logic [3:0] REQ_INTER_FIRST = 4'd3;
    localparam logic [3:0] REQ_INTER_LAST  = 4'd8;

    localparam logic [7:0] WIPES_MAX = 8'd255;

    // Wiper state machine, one-hot
    typedef enum logic [7:0] {
        ST_PARKED  = 8'b0000_0001,
        ST_PARKING = 8'b0000_0010,
        ST_SLOW    = 8'b0000_0100,
        ST_FAST    = 8'b0000_1000,
        ST_ION     = 8'b0001_0000,
        ST_PAUSE   = 8'b0010_0000,
        ST_WASH    = 8'b0100_0000,
        ST_SWIPE   = 8'b1000_0000
    } wiper_state_t;

    // Motor drive level
    typedef enum logic [1:0] {
        MOT_OFF  = 2'd0,
        MOT_SLOW = 2'd1,
        MOT_FAST = 2'd2
    } motor_speed_t;

    // Configuration registers as seen by the core
    typedef struct packed {
        logic                             enable;
        logic                             park_level;
        logic [7:0]                       wash_cycles;
        logic [INTER_COUNT-1:0][DELAY_BITS-1:0] inter_delay;
    } wmc_cfg_t;

    // One input tick
    typedef struct packed {
        logic       park_raw;
        logic       wash_in;
        logic       swipe_in;
        logic       request_valid;
        logic [3:0] request_speed;
    } wmc_item_t;

    // One result
    typedef struct packed {
        logic       slow_relay;
        logic       fast_relay;
        logic       parked_flag;
        logic       inter_flag;
        logic       wash_flag;
        logic       swipe_flag;
        logic [2:0] wiper_state;
    } wmc_result_t;

    // State number reported on the status output
    function automatic logic [2:0] state_code(input wiper_state_t st);
        logic [2:0] code;
        case (st)
            ST_PARKED:  code = 3'd0;
            ST_PARKING: code = 3'd1;
            ST_SLOW:    code = 3'd2;
            ST_FAST:    code = 3'd3;
            ST_ION:     code = 3'd4;
            ST_PAUSE:   code = 3'd5;
            ST_WASH:    code = 3'd6;
            ST_SWIPE:   code = 3'd7;
            default:    code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/wiper_motor_controller_unit.sv -----
// Top level of the wiper motor controller: stream ports, input and result registers.
`timescale 1ns / 1ps

// Wiper motor controller. Each request on the s_ stream is one 1 ms tick carrying the park
// switch, the wash and swipe switches and an optional speed request; each tick yields exactly
// one result on the m_ stream with the relay drives, status flags and the state number. A tick
// passes through the input register and then the result register, and the block sustains one
// tick per cycle while m_tready holds: the state machine update is a single pass of logic whose
// longest path is the 32-bit elapsed-time subtract and compare. Configuration writes are taken
// at any time (cfg_ready is always high) but should only be issued while no tick is in flight.

module wiper_motor_controller_unit
    import wmc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // [0] park_raw, [1] wash_in, [2] swipe_in, [3] request_valid, [7:4] request_speed
    input  logic [7:0]               s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [0] slow_relay, [1] fast_relay, [2] parked_flag, [3] inter_flag, [4] wash_flag,
    // [5] swipe_flag, [8:6] wiper_state, [15:9] zero
    output logic [15:0]              m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    wmc_cfg_t    cfg;
    wmc_item_t   item_reg;
    logic        in_valid_reg;
    wmc_result_t core_result;
    wmc_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;

    // Tick moves from input register to result register when the result slot is free or being read out
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    wmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wmc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.park_raw      <= s_tdata[0];
            item_reg.wash_in       <= s_tdata[1];
            item_reg.swipe_in      <= s_tdata[2];
            item_reg.request_valid <= s_tdata[3];
            item_reg.request_speed <= s_tdata[7:4];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.wiper_state, out_reg.swipe_flag, out_reg.wash_flag,
                       out_reg.inter_flag, out_reg.parked_flag, out_reg.fast_relay,
                       out_reg.slow_relay};

endmodule

// ----- sv/wmc_cfg.sv -----
// Configuration register file of the wiper motor controller.
`timescale 1ns / 1ps

module wmc_cfg
    import wmc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output wmc_cfg_t                 cfg
);

    logic [1:0]   control_reg;
    logic [7:0]   wash_cycles_reg;
    delay_t [INTER_COUNT-1:0] delay_reg;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg     <= 2'd0;
            wash_cycles_reg <= 8'd3;
            for (int i = 0; i < INTER_COUNT; i++) begin
                delay_reg[i] <= DELAY_BITS'(1000 * (i + 1));
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_CONTROL) begin
                control_reg <= cfg_data[1:0];
            end else if (cfg_index == REG_WASH_WIPES) begin
                wash_cycles_reg <= cfg_data[7:0];
            end else begin
                for (int i = 0; i < INTER_COUNT; i++) begin
                    if (cfg_index == REG_INTER_1 + CFG_IDX_BITS'(i)) begin
                        delay_reg[i] <= cfg_data[DELAY_BITS-1:0];
                    end
                end
            end
        end
    end

    assign cfg.enable      = control_reg[0];
    assign cfg.park_level  = control_reg[1];
    assign cfg.wash_cycles = wash_cycles_reg;
    assign cfg.inter_delay = delay_reg;

endmodule

// ----- sv/wmc_core.sv -----
// Wiper state machine: state registers and the per-tick update logic.
`timescale 1ns / 1ps

module wmc_core
    import wmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  wmc_item_t   item,
    input  wmc_cfg_t    cfg,
    output wmc_result_t result
);

    wiper_state_t state_reg, state_next;
    wiper_state_t saved_reg, saved_next;
    motor_speed_t speed_reg, speed_next;
    logic [3:0]   sel_reg, sel_next;
    delay_t       pause_len_reg, pause_len_next;
    wmc_time_t    tick_reg, tick_next;
    wmc_time_t    motor_start_reg, motor_start_next;
    wmc_time_t    pause_start_reg, pause_start_next;
    logic [7:0]   wipes_reg, wipes_next;
    logic         park_prev_reg, park_prev_next;
    logic [3:0]   flags_reg, flags_next;

    wiper_state_t st;
    logic         park;
    logic         drive_en;
    motor_speed_t drive_spd;
    wmc_time_t    el_motor;
    wmc_time_t    el_pause;
    logic [2:0]   delay_idx;

    assign park      = (item.park_raw == cfg.park_level);
    assign delay_idx = 3'(sel_reg - REQ_INTER_FIRST);

    // Next-state logic for one tick
    always_comb begin
        tick_next        = tick_reg + TIME_BITS'(1);
        saved_next       = saved_reg;
        sel_next         = sel_reg;
        pause_len_next   = pause_len_reg;
        motor_start_next = motor_start_reg;
        pause_start_next = pause_start_reg;
        wipes_next       = wipes_reg;
        park_prev_next   = park_prev_reg;
        flags_next       = flags_reg;
        speed_next       = speed_reg;
        st               = state_reg;
        drive_en         = 1'b0;
        drive_spd        = MOT_OFF;
        el_motor         = '0;
        el_pause         = '0;

        if (!cfg.enable) begin
            speed_next = MOT_OFF;
        end else begin
            if (sel_reg >= REQ_INTER_FIRST && sel_reg <= REQ_INTER_LAST) begin
                pause_len_next = cfg.inter_delay[delay_idx];
            end
            if (item.wash_in && st != ST_WASH) begin
                saved_next = st;
                st         = ST_WASH;
            end
            if (item.swipe_in && st == ST_PARKED) begin
                st = ST_SWIPE;
            end

            // Motor drive chosen by the state
            case (st)
                ST_PARKED: begin
                    drive_en = 1'b1;
                end
                ST_PARKING: begin
                    drive_en = park;
                end
                ST_SLOW: begin
                    drive_en  = 1'b1;
                    drive_spd = MOT_SLOW;
                end
                ST_FAST: begin
                    drive_en  = 1'b1;
                    drive_spd = MOT_FAST;
                end
                ST_ION: begin
                    drive_en  = 1'b1;
                    drive_spd = MOT_SLOW;
                end
                ST_PAUSE: begin
                    drive_en = 1'b1;
                end
                ST_WASH: begin
                    drive_en  = 1'b1;
                    drive_spd = (saved_next == ST_FAST) ? MOT_FAST : MOT_SLOW;
                end
                default: begin
                    drive_en  = 1'b1;
                    drive_spd = MOT_FAST;
                end
            endcase

            // Motor start time stamps a change to a running speed
            if (drive_en) begin
                if (drive_spd != speed_reg && drive_spd != MOT_OFF) begin
                    motor_start_next = tick_next;
                end
                speed_next = drive_spd;
            end

            el_motor = tick_next - motor_start_next;
            el_pause = tick_next - pause_start_reg;

            // State transitions
            case (st)
                ST_PARKED: begin
                end
                ST_PARKING: begin
                    if (park) begin
                        st       = ST_PARKED;
                        sel_next = REQ_PARK;
                    end
                end
                ST_SLOW: begin
                end
                ST_FAST: begin
                end
                ST_ION: begin
                    if (el_motor > INTER_SETTLE && park) begin
                        pause_start_next = tick_next;
                        st               = ST_PAUSE;
                    end
                end
                ST_PAUSE: begin
                    if (el_pause > TIME_BITS'(pause_len_next)) begin
                        st = ST_ION;
                    end
                end
                ST_WASH: begin
                    if (item.wash_in) begin
                        wipes_next     = 8'd0;
                        park_prev_next = park;
                    end else if (el_motor > WASH_SETTLE) begin
                        if (park && !park_prev_reg && wipes_reg < WIPES_MAX) begin
                            wipes_next = wipes_reg + 8'd1;
                        end
                        if (wipes_next >= cfg.wash_cycles) begin
                            if (saved_next == ST_PARKED) begin
                                st = ST_PARKING;
                            end else if (saved_next == ST_PAUSE) begin
                                st = ST_ION;
                            end else begin
                                st = saved_next;
                            end
                        end
                        park_prev_next = park;
                    end
                end
                default: begin
                    if (el_motor > WASH_SETTLE && park) begin
                        st = ST_PARKING;
                    end
                end
            endcase

            // Speed request from the mode logic, not during wash or swipe
            if (item.request_valid && st != ST_WASH && st != ST_SWIPE) begin
                if (item.request_speed == REQ_PARK) begin
                    sel_next = REQ_PARK;
                    if (st != ST_PARKED) begin
                        st = ST_PARKING;
                    end
                end else if (item.request_speed == REQ_SLOW) begin
                    sel_next = REQ_SLOW;
                    st       = ST_SLOW;
                end else if (item.request_speed == REQ_FAST) begin
                    sel_next = REQ_FAST;
                    st       = ST_FAST;
                end else if (item.request_speed <= REQ_INTER_LAST) begin
                    sel_next = item.request_speed;
                    if (st != ST_ION && st != ST_PAUSE) begin
                        st = ST_ION;
                    end
                end
            end

            flags_next = {st == ST_SWIPE, st == ST_WASH,
                          st == ST_ION || st == ST_PAUSE, st == ST_PARKED};
        end

        state_next = st;
    end

    // Result for this tick
    assign result.slow_relay  = (speed_next != MOT_OFF);
    assign result.fast_relay  = (speed_next == MOT_FAST);
    assign result.parked_flag = flags_next[0];
    assign result.inter_flag  = flags_next[1];
    assign result.wash_flag   = flags_next[2];
    assign result.swipe_flag  = flags_next[3];
    assign result.wiper_state = state_code(state_next);

    // State registers, updated once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_PARKED;
            saved_reg       <= ST_PARKED;
            speed_reg       <= MOT_OFF;
            sel_reg         <= REQ_PARK;
            pause_len_reg   <= '0;
            tick_reg        <= '0;
            motor_start_reg <= '0;
            pause_start_reg <= '0;
            wipes_reg       <= 8'd0;
            park_prev_reg   <= 1'b0;
            flags_reg       <= 4'd0;
        end else if (advance) begin
            state_reg       <= state_next;
            saved_reg       <= saved_next;
            speed_reg       <= speed_next;
            sel_reg         <= sel_next;
            pause_len_reg   <= pause_len_next;
            tick_reg        <= tick_next;
            motor_start_reg <= motor_start_next;
            pause_start_reg <= pause_start_next;
            wipes_reg       <= wipes_next;
            park_prev_reg   <= park_prev_next;
            flags_reg       <= flags_next;
        end
    end

endmodule
